// ===== rtl/core/ntpcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntpcd_pkg: shared types and constants for the NTP seconds to civil date block
// Stage enables, time-of-day bundle, fixed-point reciprocals and the
// month start table used by the conversion pipeline.
// ----------------------------------------------------------------------------
package ntpcd_pkg;

	// pipeline depth: stage 1 is the offset add, the last stage is the output
	localparam int NumStages = 13;

	// one load enable per pipeline stage
	typedef logic [NumStages:1] stage_en_t;

	// hour / minute / second bundle
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} hms_t;

	// 2^32 - 2208988800: adding this removes the 1900 to 1970 offset
	localparam logic [31:0] NtpToUnixAdd = 32'd2085978496;
	localparam logic [31:0] SecPerDay    = 32'd86400;

	// floor(2^k / d) reciprocals; each estimate is low by at most one
	localparam logic [25:0] Recip675   = 26'd50903316; // k = 35, on seconds >> 7
	localparam logic [17:0] Recip60Tod = 18'd139810;   // k = 23
	localparam logic [11:0] Recip60Min = 12'd2184;     // k = 17
	localparam logic [18:0] Recip1460  = 19'd367719;   // k = 29
	localparam logic [18:0] Recip365   = 19'd367719;   // k = 27
	localparam logic [11:0] Recip153   = 12'd3426;     // k = 19

	// day count arithmetic (March based eras)
	localparam logic [17:0] DoeBias  = 18'd135080;  // 719468 - 4 * 146097
	localparam logic [17:0] EraDays  = 18'd146097;
	localparam logic [11:0] YearEra4 = 12'd1600;
	localparam logic [11:0] YearEra5 = 12'd2000;

	// first day of year (from March 1) of each March based month
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] d;
		unique case (mp)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd61;
			4'd3:    d = 9'd92;
			4'd4:    d = 9'd122;
			4'd5:    d = 9'd153;
			4'd6:    d = 9'd184;
			4'd7:    d = 9'd214;
			4'd8:    d = 9'd245;
			4'd9:    d = 9'd275;
			4'd10:   d = 9'd306;
			4'd11:   d = 9'd337;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ntpcd_hms.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntpcd_hms: time of day to hour, minute and second
// Stages 4 to 7: split seconds of day into minutes and seconds, then
// minutes into hours and minutes, by reciprocal multiply and one correction.
// ----------------------------------------------------------------------------
module ntpcd_hms (
	input  wire logic                clk,
	input  wire ntpcd_pkg::stage_en_t en,
	input  wire logic [16:0]         tod,
	output ntpcd_pkg::hms_t          hms
);

	logic [34:0] prod_m;
	logic [10:0] min_est_s4;
	logic [16:0] tod_s4;
	logic [16:0] rem_s;
	logic [10:0] min_s5;
	logic [5:0]  sec_s5;
	logic [22:0] prod_h;
	logic [4:0]  hour_est_s6;
	logic [10:0] min_s6;
	logic [5:0]  sec_s6;
	logic [10:0] rem_m;
	ntpcd_pkg::hms_t hms_s7;

	// stage 4: minute estimate
	assign prod_m = 35'(tod) * 35'(ntpcd_pkg::Recip60Tod);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			min_est_s4 <= prod_m[33:23];
			tod_s4     <= tod;
		end
	end

	// stage 5: correct minute, take seconds
	assign rem_s = tod_s4 - 17'(min_est_s4) * 17'd60;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			if (rem_s >= 17'd60) begin
				min_s5 <= min_est_s4 + 11'd1;
				sec_s5 <= 6'(rem_s - 17'd60);
			end else begin
				min_s5 <= min_est_s4;
				sec_s5 <= 6'(rem_s);
			end
		end
	end

	// stage 6: hour estimate
	assign prod_h = 23'(min_s5) * 23'(ntpcd_pkg::Recip60Min);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			hour_est_s6 <= prod_h[21:17];
			min_s6      <= min_s5;
			sec_s6      <= sec_s5;
		end
	end

	// stage 7: correct hour, take minutes
	assign rem_m = min_s6 - 11'(hour_est_s6) * 11'd60;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			if (rem_m >= 11'd60) begin
				hms_s7.hour   <= hour_est_s6 + 5'd1;
				hms_s7.minute <= 6'(rem_m - 11'd60);
			end else begin
				hms_s7.hour   <= hour_est_s6;
				hms_s7.minute <= 6'(rem_m);
			end
			hms_s7.second <= sec_s6;
		end
	end

	assign hms = hms_s7;

endmodule
`default_nettype wire

// ===== rtl/core/ntpcd_civil.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntpcd_civil: day count since 1970 to Gregorian year, month and day
// Stages 4 to 13: era and day of era, year of era, day of year, March based
// month, then the final calendar fields.
// ----------------------------------------------------------------------------
module ntpcd_civil (
	input  wire logic                clk,
	input  wire ntpcd_pkg::stage_en_t en,
	input  wire logic [15:0]         days,
	output logic [11:0]              year,
	output logic [3:0]               month,
	output logic [4:0]               day_of_month
);

	logic [17:0] z;
	logic        era5_s4, era5_s5, era5_s6, era5_s7, era5_s8, era5_s9;
	logic [17:0] doe_s4, doe_s5, doe_s6, doe_s7, doe_s8, doe_s9;
	logic [36:0] prod_a;
	logic [6:0]  a_est_s5;
	logic [2:0]  c36_s5, c36_s6;
	logic        c146_s5, c146_s6;
	logic [17:0] rem_a;
	logic [6:0]  a_s6;
	logic [17:0] n_s7, n_s8;
	logic [36:0] prod_y;
	logic [8:0]  y_est_s8;
	logic [17:0] rem_y;
	logic [8:0]  yoe_s9;
	logic [1:0]  c100;
	logic [17:0] doy_base;
	logic [8:0]  doy_s10, doy_s11, doy_s12;
	logic [11:0] year_s10, year_s11, year_s12;
	logic [10:0] x_mp;
	logic [22:0] prod_mp;
	logic [10:0] x_s11;
	logic [3:0]  mp_est_s11;
	logic [10:0] rem_mp;
	logic [3:0]  mp_s12;
	logic [3:0]  mo;
	logic [11:0] year_s13;
	logic [3:0]  month_s13;
	logic [4:0]  day_s13;

	// stage 4: era (4 or 5 for this range) and day of era
	assign z = 18'(days) + ntpcd_pkg::DoeBias;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			era5_s4 <= (z >= ntpcd_pkg::EraDays);
			doe_s4  <= (z >= ntpcd_pkg::EraDays) ? z - ntpcd_pkg::EraDays : z;
		end
	end

	// stage 5: doe / 1460 estimate, doe / 36524 and doe / 146096 by compare
	assign prod_a = 37'(doe_s4) * 37'(ntpcd_pkg::Recip1460);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			a_est_s5 <= prod_a[35:29];
			c36_s5   <= 3'(doe_s4 >= 18'd36524) + 3'(doe_s4 >= 18'd73048)
				+ 3'(doe_s4 >= 18'd109572) + 3'(doe_s4 >= 18'd146096);
			c146_s5  <= (doe_s4 == 18'd146096);
			doe_s5   <= doe_s4;
			era5_s5  <= era5_s4;
		end
	end

	// stage 6: correct doe / 1460
	assign rem_a = doe_s5 - 18'(a_est_s5) * 18'd1460;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			a_s6    <= a_est_s5 + 7'(rem_a >= 18'd1460);
			c36_s6  <= c36_s5;
			c146_s6 <= c146_s5;
			doe_s6  <= doe_s5;
			era5_s6 <= era5_s5;
		end
	end

	// stage 7: leap day adjusted day count
	always_ff @(posedge clk) begin
		if (en[7]) begin
			n_s7    <= doe_s6 - 18'(a_s6) + 18'(c36_s6) - 18'(c146_s6);
			doe_s7  <= doe_s6;
			era5_s7 <= era5_s6;
		end
	end

	// stage 8: year of era estimate
	assign prod_y = 37'(n_s7) * 37'(ntpcd_pkg::Recip365);

	always_ff @(posedge clk) begin
		if (en[8]) begin
			y_est_s8 <= prod_y[35:27];
			n_s8     <= n_s7;
			doe_s8   <= doe_s7;
			era5_s8  <= era5_s7;
		end
	end

	// stage 9: correct year of era
	assign rem_y = n_s8 - 18'(y_est_s8) * 18'd365;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			yoe_s9  <= y_est_s8 + 9'(rem_y >= 18'd365);
			doe_s9  <= doe_s8;
			era5_s9 <= era5_s8;
		end
	end

	// stage 10: day of year (from March 1) and March based year
	assign c100 = 2'(yoe_s9 >= 9'd100) + 2'(yoe_s9 >= 9'd200) + 2'(yoe_s9 >= 9'd300);
	assign doy_base = 18'(yoe_s9) * 18'd365 + 18'(yoe_s9[8:2]) - 18'(c100);

	always_ff @(posedge clk) begin
		if (en[10]) begin
			doy_s10  <= 9'(doe_s9 - doy_base);
			year_s10 <= 12'(yoe_s9) + (era5_s9 ? ntpcd_pkg::YearEra5 : ntpcd_pkg::YearEra4);
		end
	end

	// stage 11: month estimate, (5 * doy + 2) / 153
	assign x_mp    = 11'(doy_s10) * 11'd5 + 11'd2;
	assign prod_mp = 23'(x_mp) * 23'(ntpcd_pkg::Recip153);

	always_ff @(posedge clk) begin
		if (en[11]) begin
			mp_est_s11 <= prod_mp[22:19];
			x_s11      <= x_mp;
			doy_s11    <= doy_s10;
			year_s11   <= year_s10;
		end
	end

	// stage 12: correct month
	assign rem_mp = x_s11 - 11'(mp_est_s11) * 11'd153;

	always_ff @(posedge clk) begin
		if (en[12]) begin
			mp_s12   <= mp_est_s11 + 4'(rem_mp >= 11'd153);
			doy_s12  <= doy_s11;
			year_s12 <= year_s11;
		end
	end

	// stage 13: calendar month, day, and January / February year bump
	assign mo = (mp_s12 < 4'd10) ? mp_s12 + 4'd3 : mp_s12 - 4'd9;

	always_ff @(posedge clk) begin
		if (en[13]) begin
			month_s13 <= mo;
			day_s13   <= 5'(doy_s12 - ntpcd_pkg::month_start(mp_s12) + 9'd1);
			year_s13  <= year_s12 + 12'(mo <= 4'd2);
		end
	end

	assign year         = year_s13;
	assign month        = month_s13;
	assign day_of_month = day_s13;

endmodule
`default_nettype wire

// ===== rtl/core/ntp_seconds_to_civil_date.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntp_seconds_to_civil_date: NTP seconds to Unix seconds and UTC date/time
// Removes the 1900 epoch, adds a signed minute offset, and splits the result
// into civil date and time of day; flags an unsynchronized server.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   ntp_seconds, leap_indicator
//   out       output     out_valid / out_ready unix_seconds, year, month,
//                                              day_of_month, hour, minute,
//                                              second, unsynchronized
//   cfg       input      cfg_wr_en             cfg_wr_data (offset_minutes)
//
// 13 register stages, stage 1 to stage 13; out_valid is the valid bit of stage 13,
// and the pipeline takes one item per cycle while out_ready is high.
// The depth is set by the chain of constant divisions on the day count.
// Reset clears stage valid bits and the offset register (to 0).
// A stall on out_ready holds each full stage that has no empty stage after it; an empty
// stage still loads, so bubbles close up and in_ready stays high while any room is left.
// ----------------------------------------------------------------------------
module ntp_seconds_to_civil_date (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_wr_en,
	input  wire logic [11:0] cfg_wr_data,
	// input items
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] ntp_seconds,
	input  wire logic [1:0]  leap_indicator,
	// result items
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      unix_seconds,
	output logic [11:0]      year,
	output logic [3:0]       month,
	output logic [4:0]       day_of_month,
	output logic [4:0]       hour,
	output logic [5:0]       minute,
	output logic [5:0]       second,
	output logic             unsynchronized
);

	localparam int N = ntpcd_pkg::NumStages;

	typedef struct packed {
		logic [31:0] unix;
		logic        unsync;
	} side_t;

	logic [11:0]          offset_q;
	logic [N:1]           stage_vld_q;
	ntpcd_pkg::stage_en_t en;

	logic [31:0] shift;
	logic [31:0] unix_s1, unix_s2, unix_s3;
	logic        unsync_s1, unsync_s2, unsync_s3;
	logic [50:0] prod_d;
	logic [15:0] day_est_s2;
	logic [31:0] rem_d;
	logic [15:0] days_s3;
	logic [16:0] tod_s3;
	side_t           side_s [4:N];
	ntpcd_pkg::hms_t hms_s7;
	ntpcd_pkg::hms_t hms_s [8:N];

	// offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_wr_en) begin
			offset_q <= cfg_wr_data;
		end
	end

	// stage load enables: a stage loads when empty or when the next one moves
	always_comb begin
		en[N] = !stage_vld_q[N] || out_ready;
		for (int i = N - 1; i >= 1; i--) begin
			en[i] = !stage_vld_q[i] || en[i + 1];
		end
	end

	assign in_ready = en[1];

	// valid bits travel with the items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (en[1]) begin
				stage_vld_q[1] <= in_valid;
			end
			for (int i = 2; i <= N; i++) begin
				if (en[i]) begin
					stage_vld_q[i] <= stage_vld_q[i - 1];
				end
			end
		end
	end

	// stage 1: epoch removal and offset, modulo 2^32
	assign shift = {{20{offset_q[11]}}, offset_q} * 32'd60;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			unix_s1   <= ntp_seconds + ntpcd_pkg::NtpToUnixAdd + shift;
			unsync_s1 <= (leap_indicator == 2'b11);
		end
	end

	// stage 2: day estimate, (seconds >> 7) / 675
	assign prod_d = 51'(unix_s1[31:7]) * 51'(ntpcd_pkg::Recip675);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			day_est_s2 <= prod_d[50:35];
			unix_s2    <= unix_s1;
			unsync_s2  <= unsync_s1;
		end
	end

	// stage 3: correct day count, seconds of day
	assign rem_d = unix_s2 - 32'(day_est_s2) * ntpcd_pkg::SecPerDay;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			if (rem_d >= ntpcd_pkg::SecPerDay) begin
				days_s3 <= day_est_s2 + 16'd1;
				tod_s3  <= 17'(rem_d - ntpcd_pkg::SecPerDay);
			end else begin
				days_s3 <= day_est_s2;
				tod_s3  <= 17'(rem_d);
			end
			unix_s3   <= unix_s2;
			unsync_s3 <= unsync_s2;
		end
	end

	// stages 4 to 7: hour, minute, second
	ntpcd_hms u_hms (
		.clk (clk),
		.en  (en),
		.tod (tod_s3),
		.hms (hms_s7)
	);

	// stages 4 to 13: year, month, day
	ntpcd_civil u_civil (
		.clk          (clk),
		.en           (en),
		.days         (days_s3),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month)
	);

	// side fields ride along to the output stage
	always_ff @(posedge clk) begin
		if (en[4]) begin
			side_s[4] <= '{unix: unix_s3, unsync: unsync_s3};
		end
	end

	for (genvar g = 5; g <= N; g++) begin : g_side
		always_ff @(posedge clk) begin
			if (en[g]) begin
				side_s[g] <= side_s[g - 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			hms_s[8] <= hms_s7;
		end
	end

	for (genvar g = 9; g <= N; g++) begin : g_hms
		always_ff @(posedge clk) begin
			if (en[g]) begin
				hms_s[g] <= hms_s[g - 1];
			end
		end
	end

	// outputs
	assign out_valid      = stage_vld_q[N];
	assign unix_seconds   = side_s[N].unix;
	assign unsynchronized = side_s[N].unsync;
	assign hour           = hms_s[N].hour;
	assign minute         = hms_s[N].minute;
	assign second         = hms_s[N].second;

endmodule
`default_nettype wire
